@@ rtl/core/cfgb_pkg.sv @@
// shared constants and types for the csr fanout graph builder
// depends on nothing; used by every module under rtl/core except cfgb_ram
package cfgb_pkg;

  localparam int MaxWires  = 1024;
  localparam int MaxGates  = 1024;
  localparam int MaxEdges  = 2048;
  localparam int WireW     = $clog2(MaxWires);
  localparam int GateW     = $clog2(MaxGates);
  localparam int EdgeW     = $clog2(MaxEdges);
  localparam int CntW      = EdgeW + 1;
  localparam int WtotW     = WireW + 1;
  localparam int GfillW    = GateW + 1;
  localparam int GateRecW  = 3 * WireW + 1;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_BUILD = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  localparam logic CFG_WIRE_TOTAL  = 1'b0;
  localparam logic CFG_INPUT_TOTAL = 1'b1;

  // datapath phase select
  typedef enum logic [2:0] {
    PH_CLEAR   = 3'd0,
    PH_COUNT   = 3'd1,
    PH_PREFIX  = 3'd2,
    PH_SCATTER = 3'd3,
    PH_CMD     = 3'd4
  } phase_t;

  typedef struct packed {
    logic   cnt_clr;     // reset sweep counter
    logic   cnt_step;    // advance sweep counter
    phase_t phase;       // which sweep drives the rams
    logic   cmd_issue;   // launch single-access command
    logic   cmd_finish;  // produce command result
    logic   build_done;  // commit build result
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;    // sweep counter at final element
    logic edge_ovf;      // counted edges exceed limit
  } dp_stat_t;

endpackage

@@ rtl/core/cfgb_ram.sv @@
// generic single-port-write, one-read ram with registered read data
// no dependencies
module cfgb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/cfgb_ctrl.sv @@
// build and command sequencer
// depends on cfgb_pkg
module cfgb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_mode,
  input  cfgb_pkg::dp_stat_t stat,
  output logic              busy,
  output cfgb_pkg::dp_cmd_t cmd
);
  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_CMD     = 7'b0000010,
    S_CLEAR   = 7'b0000100,
    S_COUNT   = 7'b0001000,
    S_PREFIX  = 7'b0010000,
    S_SCATTER = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.phase = cfgb_pkg::PH_CMD;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.cnt_clr = 1'b1;
          if (in_mode == cfgb_pkg::MODE_BUILD) begin
            state_nxt = S_CLEAR;
          end else begin
            cmd.cmd_issue = 1'b1;
            state_nxt = S_CMD;
          end
        end
      end
      S_CMD: begin
        cmd.cmd_finish = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CLEAR: begin
        cmd.phase = cfgb_pkg::PH_CLEAR;
        cmd.cnt_step = 1'b1;
        if (stat.sweep_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt = S_COUNT;
        end
      end
      S_COUNT: begin
        cmd.phase = cfgb_pkg::PH_COUNT;
        cmd.cnt_step = 1'b1;
        if (stat.sweep_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt = S_PREFIX;
        end
      end
      S_PREFIX: begin
        cmd.phase = cfgb_pkg::PH_PREFIX;
        cmd.cnt_step = 1'b1;
        if (stat.edge_ovf) begin
          state_nxt = S_DONE;
        end else if (stat.sweep_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt = S_SCATTER;
        end
      end
      S_SCATTER: begin
        cmd.phase = cfgb_pkg::PH_SCATTER;
        cmd.cnt_step = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.build_done = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_cmd_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMD) |=> (state_r == S_IDLE))
    else $error("command took more than one cycle");
  a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> !busy)
    else $error("build did not end");
endmodule

@@ rtl/core/cfgb_dp.sv @@
// gate, count, offset and neighbor stores with sweep counter and result registers
// depends on cfgb_pkg and cfgb_ram
module cfgb_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cfgb_pkg::dp_cmd_t                 cmd,
  output cfgb_pkg::dp_stat_t                stat,
  input  logic                              start,
  input  logic [1:0]                        in_mode,
  input  logic [cfgb_pkg::WireW-1:0]        in_first_wire,
  input  logic [cfgb_pkg::WireW-1:0]        in_second_wire,
  input  logic [cfgb_pkg::WireW-1:0]        in_out_wire,
  input  logic                              in_dead,
  input  logic [cfgb_pkg::WireW-1:0]        in_query_wire,
  input  logic [cfgb_pkg::EdgeW-1:0]        in_entry_index,
  input  logic [cfgb_pkg::WtotW-1:0]        wire_total,
  output logic                              out_valid,
  output logic                              out_status,
  output logic [cfgb_pkg::CntW-1:0]         out_start_offset,
  output logic [cfgb_pkg::CntW-1:0]         out_fanout_count,
  output logic [cfgb_pkg::WireW-1:0]        out_neighbor_wire
);
  localparam int WireW = cfgb_pkg::WireW;
  localparam int GateW = cfgb_pkg::GateW;
  localparam int EdgeW = cfgb_pkg::EdgeW;
  localparam int CntW  = cfgb_pkg::CntW;
  localparam int WtotW = cfgb_pkg::WtotW;
  localparam int GfW   = cfgb_pkg::GfillW;
  localparam int RecW  = cfgb_pkg::GateRecW;
  localparam int SwW   = (GfW > WtotW) ? GfW : WtotW;
  // each gate passes through sub steps in the count and scatter sweeps: read addr, read data, rmw a, rmw b
  localparam int SubW  = 2;

  // effective wire count
  logic [WtotW-1:0] n_wires;
  assign n_wires = (wire_total > WtotW'(cfgb_pkg::MaxWires)) ?
                   WtotW'(cfgb_pkg::MaxWires) : wire_total;

  // sweep counter: element index and sub step
  logic [SwW-1:0]  idx_r, idx_nxt;
  logic [SubW-1:0] sub_r, sub_nxt;
  logic [GfW-1:0]  gate_fill_r;
  logic            built_r;
  logic [WtotW-1:0] built_wires_r;
  logic [CntW:0]    total_r;
  logic [CntW-1:0]  built_edges_r;
  logic [CntW-1:0]  run_r;          // prefix running sum
  logic [WireW-1:0] gin_a_r, gin_b_r, gout_r;
  logic             glive_r;

  // rams
  logic             g_we;
  logic [GateW-1:0] g_wa, g_ra;
  logic [RecW-1:0]  g_wd, g_rd;
  logic             c_we;
  logic [WireW-1:0] c_wa, c_ra;
  logic [CntW-1:0]  c_wd, c_rd;
  logic             o_we;
  logic [WtotW-1:0] o_wa, o_ra;
  logic [CntW-1:0]  o_wd, o_rd;
  logic             k_we;   // cursor store
  logic [WireW-1:0] k_wa, k_ra;
  logic [CntW-1:0]  k_wd, k_rd;
  logic             nb_we;
  logic [EdgeW-1:0] nb_wa, nb_ra;
  logic [WireW-1:0] nb_wd, nb_rd;

  cfgb_ram #(.Width(RecW), .Depth(cfgb_pkg::MaxGates)) u_gate (
    .clk, .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata(g_rd));
  cfgb_ram #(.Width(CntW), .Depth(cfgb_pkg::MaxWires)) u_count (
    .clk, .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));
  cfgb_ram #(.Width(CntW), .Depth(2 ** WtotW)) u_offset (
    .clk, .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd));
  cfgb_ram #(.Width(CntW), .Depth(cfgb_pkg::MaxWires)) u_cursor (
    .clk, .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));
  cfgb_ram #(.Width(WireW), .Depth(cfgb_pkg::MaxEdges)) u_nbr (
    .clk, .we(nb_we), .waddr(nb_wa), .wdata(nb_wd), .raddr(nb_ra), .rdata(nb_rd));

  // decoded gate record from ram
  logic [WireW-1:0] rd_a, rd_b, rd_o;
  logic             rd_dead, rd_live;
  assign {rd_a, rd_b, rd_o, rd_dead} = g_rd;
  assign rd_live = !rd_dead && ({1'b0, rd_a} < n_wires) && ({1'b0, rd_b} < n_wires);

  // latched command fields
  logic [1:0]       mode_r;
  logic             err_r;

  logic load_ok;
  assign load_ok = (gate_fill_r < GfW'(cfgb_pkg::MaxGates)) &&
                   ({1'b0, in_first_wire} < n_wires) &&
                   ({1'b0, in_second_wire} < n_wires) &&
                   ({1'b0, in_out_wire} < n_wires);

  logic [SwW-1:0] sweep_end;
  always_comb begin
    case (cmd.phase)
      cfgb_pkg::PH_CLEAR:  sweep_end = SwW'(cfgb_pkg::MaxWires - 1);
      cfgb_pkg::PH_PREFIX: sweep_end = SwW'(n_wires);
      default:             sweep_end = SwW'(gate_fill_r);
    endcase
  end

  always_comb begin
    stat.edge_ovf = (total_r > (CntW + 1)'(cfgb_pkg::MaxEdges));
    case (cmd.phase)
      cfgb_pkg::PH_CLEAR:  stat.sweep_last = (idx_r == sweep_end);
      cfgb_pkg::PH_PREFIX: stat.sweep_last = (idx_r == sweep_end) && (sub_r == 2'd1);
      default:             stat.sweep_last = (idx_r == sweep_end);
    endcase
  end

  // ram port steering
  always_comb begin
    g_we = 1'b0; g_wa = gate_fill_r[GateW-1:0];
    g_wd = {in_first_wire, in_second_wire, in_out_wire, in_dead};
    g_ra = idx_r[GateW-1:0];
    c_we = 1'b0; c_wa = idx_r[WireW-1:0]; c_wd = '0; c_ra = gin_a_r;
    o_we = 1'b0; o_wa = idx_r[WtotW-1:0]; o_wd = run_r;
    o_ra = {1'b0, in_query_wire};
    k_we = 1'b0; k_wa = idx_r[WireW-1:0]; k_wd = run_r; k_ra = gin_a_r;
    nb_we = 1'b0; nb_wa = k_rd[EdgeW-1:0]; nb_wd = gout_r;
    nb_ra = in_entry_index;
    idx_nxt = idx_r; sub_nxt = sub_r;
    case (cmd.phase)
      cfgb_pkg::PH_CLEAR: begin
        c_we = 1'b1;
        idx_nxt = idx_r + 1'b1;
      end
      cfgb_pkg::PH_COUNT: begin
        // sub 0 issue gate read, 1 latch gate + read count a,
        // 2 write a + read count b, 3 write b
        case (sub_r)
          2'd1: begin
            c_ra = rd_a;
          end
          2'd2: begin
            c_we = glive_r; c_wa = gin_a_r; c_wd = c_rd + 1'b1; c_ra = gin_b_r;
          end
          2'd3: begin
            // same wire twice: count already bumped once
            c_we = glive_r; c_wa = gin_b_r;
            c_wd = (gin_a_r == gin_b_r) ? c_rd + CntW'(2) : c_rd + 1'b1;
          end
          default: ;
        endcase
        if (idx_r != sweep_end) begin
          sub_nxt = sub_r + 1'b1;
          if (sub_r == 2'd3) idx_nxt = idx_r + 1'b1;
        end
      end
      cfgb_pkg::PH_PREFIX: begin
        // sub 0 read count, 1 write offset and cursor
        c_ra = idx_r[WireW-1:0];
        if (sub_r == 2'd1) begin
          o_we = 1'b1;
          k_we = (idx_r != SwW'(n_wires));
          sub_nxt = 2'd0;
          idx_nxt = idx_r + 1'b1;
        end else begin
          sub_nxt = 2'd1;
        end
      end
      cfgb_pkg::PH_SCATTER: begin
        case (sub_r)
          2'd1: begin
            k_ra = rd_a;
          end
          2'd2: begin
            nb_we = glive_r; k_we = glive_r; k_wa = gin_a_r; k_wd = k_rd + 1'b1;
            k_ra = gin_b_r;
          end
          2'd3: begin
            nb_we = glive_r; k_we = glive_r; k_wa = gin_b_r;
            nb_wa = (gin_a_r == gin_b_r) ? EdgeW'(k_rd + 1'b1) : k_rd[EdgeW-1:0];
            k_wd = (gin_a_r == gin_b_r) ? k_rd + CntW'(2) : k_rd + 1'b1;
          end
          default: ;
        endcase
        if (idx_r != sweep_end) begin
          sub_nxt = sub_r + 1'b1;
          if (sub_r == 2'd3) idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        g_we = start && cmd.cmd_issue && (in_mode == cfgb_pkg::MODE_LOAD) && load_ok;
        // query reads offset and fanout count of the wire in the issue cycle
        o_ra = {1'b0, in_query_wire};
        c_ra = in_query_wire;
      end
    endcase
    if (cmd.cnt_clr) begin
      idx_nxt = '0;
      sub_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      sub_r       <= '0;
      gate_fill_r <= '0;
      built_r     <= 1'b0;
      built_wires_r <= '0;
      built_edges_r <= '0;
      total_r     <= '0;
      out_valid   <= 1'b0;
    end else begin
      idx_r     <= idx_nxt;
      sub_r     <= sub_nxt;
      out_valid <= cmd.cmd_finish || cmd.build_done;
      if (cmd.cmd_issue && in_mode == cfgb_pkg::MODE_LOAD && load_ok) begin
        gate_fill_r <= gate_fill_r + 1'b1;
      end
      if (cmd.phase == cfgb_pkg::PH_CLEAR) begin
        built_r <= 1'b0;
        total_r <= '0;
      end
      if (cmd.phase == cfgb_pkg::PH_COUNT && sub_r == 2'd1 && rd_live) begin
        total_r <= total_r + (CntW + 1)'(2);
      end
      if (cmd.build_done && !stat.edge_ovf) begin
        built_r       <= 1'b1;
        built_wires_r <= n_wires;
        built_edges_r <= total_r[CntW-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if ((cmd.phase == cfgb_pkg::PH_COUNT || cmd.phase == cfgb_pkg::PH_SCATTER) &&
        sub_r == 2'd1) begin
      gin_a_r <= rd_a; gin_b_r <= rd_b; gout_r <= rd_o; glive_r <= rd_live;
    end
    if (cmd.phase == cfgb_pkg::PH_COUNT && sub_r == 2'd0) begin
      glive_r <= 1'b0;
    end
    if (cmd.phase == cfgb_pkg::PH_SCATTER && sub_r == 2'd0) begin
      glive_r <= 1'b0;
    end
    if (cmd.cnt_clr) begin
      run_r <= '0;
    end else if (cmd.phase == cfgb_pkg::PH_PREFIX && sub_r == 2'd1) begin
      run_r <= run_r + ((idx_r == SwW'(n_wires)) ? '0 : c_rd);
    end
    if (cmd.cmd_issue) begin
      mode_r <= in_mode;
      case (in_mode)
        cfgb_pkg::MODE_LOAD:  err_r <= !load_ok;
        cfgb_pkg::MODE_QUERY: err_r <= !built_r || ({1'b0, in_query_wire} >= built_wires_r);
        cfgb_pkg::MODE_READ:  err_r <= !built_r ||
                                       ({1'b0, in_entry_index} >= built_edges_r);
        default:              err_r <= 1'b1;
      endcase
    end
  end

  // result drive: count store holds the fanout of each wire after a good build
  always_ff @(posedge clk) begin
    if (cmd.cmd_finish || cmd.build_done) begin
      out_status       <= cmd.cmd_finish ? err_r : stat.edge_ovf;
      out_start_offset <= (cmd.cmd_finish && !err_r && mode_r == cfgb_pkg::MODE_QUERY) ?
                          o_rd : '0;
      out_fanout_count <= (cmd.cmd_finish && !err_r && mode_r == cfgb_pkg::MODE_QUERY) ?
                          c_rd : '0;
      out_neighbor_wire <= (cmd.cmd_finish && !err_r && mode_r == cfgb_pkg::MODE_READ) ?
                           nb_rd : '0;
    end
  end
endmodule

@@ rtl/core/csr_fanout_graph_builder.sv @@
// csr fanout graph builder top level: controller plus datapath
// load, query and read: one word in, result strobed from the output registers after the command state
// build: clear, count, prefix and scatter sweeps over the loaded gates and the effective wires
// the count store clear sweep over all 1024 entries is part of every build
// rst_n synchronous: config registers, gate fill, built flag and sequencer cleared, stores untouched
// results cannot be stalled; out_valid lasts one cycle per word
module csr_fanout_graph_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [9:0]  in_first_wire,
  input  logic [9:0]  in_second_wire,
  input  logic [9:0]  in_out_wire,
  input  logic        in_dead,
  input  logic [9:0]  in_query_wire,
  input  logic [10:0] in_entry_index,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_wdata,
  output logic        out_valid,
  output logic        out_status,
  output logic [11:0] out_start_offset,
  output logic [11:0] out_fanout_count,
  output logic [9:0]  out_neighbor_wire
);
  cfgb_pkg::dp_cmd_t  cmd;
  cfgb_pkg::dp_stat_t stat;

  // config registers; input count kept for software only
  logic [10:0] wire_total_r;
  logic [10:0] input_wire_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wire_total_r       <= '0;
      input_wire_total_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cfgb_pkg::CFG_WIRE_TOTAL:  wire_total_r       <= cfg_wdata;
        cfgb_pkg::CFG_INPUT_TOTAL: input_wire_total_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic gated_start;
  assign gated_start = start && !busy;

  cfgb_ctrl u_ctrl (
    .clk, .rst_n, .start(gated_start), .in_mode, .stat, .busy, .cmd);

  cfgb_dp u_dp (
    .clk, .rst_n, .cmd, .stat, .start(gated_start), .in_mode,
    .in_first_wire, .in_second_wire, .in_out_wire, .in_dead,
    .in_query_wire, .in_entry_index, .wire_total(wire_total_r),
    .out_valid, .out_status, .out_start_offset, .out_fanout_count,
    .out_neighbor_wire);

  logic unused_cfg;
  assign unused_cfg = ^input_wire_total_r;

  a_strobe_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (gated_start && in_mode != cfgb_pkg::MODE_BUILD) |=> ##1 out_valid)
    else $error("missing result word");
  a_no_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result word without command");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_start_offset == '0 && out_neighbor_wire == '0))
    else $error("error word carries data");
endmodule

@@ bench/tb_csr_fanout_graph_builder.sv @@
// self-checking bench for the csr fanout graph builder: command words in, result words out
// depends on cfgb_pkg and the csr_fanout_graph_builder rtl; own prediction of the graph build
`timescale 1ns / 100ps

module tb_csr_fanout_graph_builder;

  localparam int CycleLimit = 3000000;

  // one command word as the sender sees it
  typedef struct {
    logic [1:0]  mode;
    logic [9:0]  first_wire;
    logic [9:0]  second_wire;
    logic [9:0]  out_wire;
    logic        dead;
    logic [9:0]  query_wire;
    logic [10:0] entry_index;
    bit          drain;       // hold this word until every answer is back
  } cmd_word_t;

  // one result word
  typedef struct {
    logic        status;
    logic [11:0] start_offset;
    logic [11:0] fanout_count;
    logic [9:0]  neighbor_wire;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_mode = cfgb_pkg::MODE_LOAD;
  logic [9:0]  in_first_wire = '0;
  logic [9:0]  in_second_wire = '0;
  logic [9:0]  in_out_wire = '0;
  logic        in_dead = 1'b0;
  logic [9:0]  in_query_wire = '0;
  logic [10:0] in_entry_index = '0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = cfgb_pkg::CFG_WIRE_TOTAL;
  logic [10:0] cfg_wdata = '0;
  logic        out_valid;
  logic        out_status;
  logic [11:0] out_start_offset;
  logic [11:0] out_fanout_count;
  logic [9:0]  out_neighbor_wire;

  csr_fanout_graph_builder u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_first_wire    (in_first_wire),
    .in_second_wire   (in_second_wire),
    .in_out_wire      (in_out_wire),
    .in_dead          (in_dead),
    .in_query_wire    (in_query_wire),
    .in_entry_index   (in_entry_index),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_start_offset (out_start_offset),
    .out_fanout_count (out_fanout_count),
    .out_neighbor_wire(out_neighbor_wire)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // predicted block state: gate list, csr arrays, latched build results
  // ---------------------------------------------------------------------
  int unsigned wire_total_q;
  int unsigned input_total_q;       // only kept, never affects results
  int unsigned gate_a [cfgb_pkg::MaxGates];
  int unsigned gate_b [cfgb_pkg::MaxGates];
  int unsigned gate_o [cfgb_pkg::MaxGates];
  bit          gate_dead [cfgb_pkg::MaxGates];
  int unsigned gate_count;
  int unsigned fanout_cnt [cfgb_pkg::MaxWires];
  int unsigned offsets [cfgb_pkg::MaxWires + 1];
  int unsigned neighbors [cfgb_pkg::MaxEdges];
  bit          graph_built;
  int unsigned graph_wires;
  int unsigned graph_edges;

  cmd_word_t pend_q [$];    // words waiting for the driver
  answer_t   answer_q [$];  // predicted results in order
  bit        took;          // word accepted at the last rising edge
  int        burst_left = 4;
  int        gap_left = 0;
  int        mismatches = 0;
  int        cycles = 0;
  int        gen_wires;     // wire count the generator assumes

  // registers above the wire limit behave as the limit
  function automatic int unsigned live_wires();
    return (wire_total_q > cfgb_pkg::MaxWires) ? cfgb_pkg::MaxWires : wire_total_q;
  endfunction

  // counting sort of live gates into per-wire neighbor lists
  function automatic bit rebuild_graph();
    int unsigned n;
    int unsigned total;
    int unsigned cur [cfgb_pkg::MaxWires];
    n = live_wires();
    total = 0;
    graph_built = 1'b0;
    for (int w = 0; w < cfgb_pkg::MaxWires; w++) fanout_cnt[w] = 0;
    for (int g = 0; g < gate_count; g++) begin
      // skipped: dead, or an input beyond a shrunken wire count
      if (gate_dead[g] || gate_a[g] >= n || gate_b[g] >= n) continue;
      fanout_cnt[gate_a[g]]++;
      fanout_cnt[gate_b[g]]++;
      total += 2;
    end
    if (total > cfgb_pkg::MaxEdges) return 1'b0;
    offsets[0] = 0;
    for (int w = 0; w < n; w++) begin
      offsets[w + 1] = offsets[w] + fanout_cnt[w];
      cur[w] = offsets[w];
    end
    // first input before second input, in gate order
    for (int g = 0; g < gate_count; g++) begin
      if (gate_dead[g] || gate_a[g] >= n || gate_b[g] >= n) continue;
      neighbors[cur[gate_a[g]]] = gate_o[g];
      cur[gate_a[g]]++;
      neighbors[cur[gate_b[g]]] = gate_o[g];
      cur[gate_b[g]]++;
    end
    graph_wires = n;
    graph_edges = total;
    graph_built = 1'b1;
    return 1'b1;
  endfunction

  function automatic answer_t predict_answer(cmd_word_t w);
    answer_t r;
    int unsigned n;
    r = '{status: 1'b0, start_offset: '0, fanout_count: '0, neighbor_wire: '0};
    case (w.mode)
      cfgb_pkg::MODE_LOAD: begin
        n = live_wires();
        // full store or any wire out of range: flagged, nothing stored
        if (gate_count >= cfgb_pkg::MaxGates || w.first_wire >= n || w.second_wire >= n ||
            w.out_wire >= n) begin
          r.status = 1'b1;
        end else begin
          gate_a[gate_count] = w.first_wire;
          gate_b[gate_count] = w.second_wire;
          gate_o[gate_count] = w.out_wire;
          gate_dead[gate_count] = w.dead;
          gate_count++;
        end
      end
      cfgb_pkg::MODE_BUILD: r.status = !rebuild_graph();
      cfgb_pkg::MODE_QUERY: begin
        if (!graph_built || w.query_wire >= graph_wires) begin
          r.status = 1'b1;
        end else begin
          r.start_offset = 12'(offsets[w.query_wire]);
          r.fanout_count = 12'(offsets[w.query_wire + 1] - offsets[w.query_wire]);
        end
      end
      default: begin
        if (!graph_built || w.entry_index >= graph_edges) r.status = 1'b1;
        else r.neighbor_wire = 10'(neighbors[w.entry_index]);
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // acceptance: predict on each accepted word, track each register write
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    cmd_word_t w;
    took = rst_n && start && !busy;
    if (took) begin
      w.mode = in_mode;
      w.first_wire = in_first_wire;
      w.second_wire = in_second_wire;
      w.out_wire = in_out_wire;
      w.dead = in_dead;
      w.query_wire = in_query_wire;
      w.entry_index = in_entry_index;
      w.drain = 1'b0;
      answer_q.push_back(predict_answer(w));
    end
    if (rst_n && cfg_we) begin
      if (cfg_index == cfgb_pkg::CFG_WIRE_TOTAL) wire_total_q = cfg_wdata;
      else input_total_q = cfg_wdata;
    end
  end

  // ---------------------------------------------------------------------
  // driver: bursts of words with random gaps, changes on the falling edge
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    cmd_word_t w;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !took) begin
      // word still waiting on busy, hold it
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left--;
    end else if (pend_q.size() > 0 && !(pend_q[0].drain && answer_q.size() > 0)) begin
      w = pend_q.pop_front();
      in_mode <= w.mode;
      in_first_wire <= w.first_wire;
      in_second_wire <= w.second_wire;
      in_out_wire <= w.out_wire;
      in_dead <= w.dead;
      in_query_wire <= w.query_wire;
      in_entry_index <= w.entry_index;
      start <= 1'b1;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 16);
        // about a third of bursts run straight into the next one
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      start <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // monitor: every strobed result word against the oldest prediction
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_valid) begin
      if (answer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at cycle %0d", cycles);
      end else begin
        e = answer_q.pop_front();
        if (out_status !== e.status || out_start_offset !== e.start_offset ||
            out_fanout_count !== e.fanout_count || out_neighbor_wire !== e.neighbor_wire) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch cycle %0d: status %0d/%0d offset %0d/%0d count %0d/%0d nbr %0d/%0d",
                     cycles, e.status, out_status, e.start_offset, out_start_offset,
                     e.fanout_count, out_fanout_count, e.neighbor_wire, out_neighbor_wire);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_csr_fanout_graph_builder: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  task automatic push_word(logic [1:0] mode, int a, int b, int o, bit dead, int qw, int ei,
                           bit drain = 1'b0);
    cmd_word_t w;
    w.mode = mode;
    w.first_wire = 10'(a);
    w.second_wire = 10'(b);
    w.out_wire = 10'(o);
    w.dead = dead;
    w.query_wire = 10'(qw);
    w.entry_index = 11'(ei);
    w.drain = drain;
    pend_q.push_back(w);
  endtask

  // block idle: nothing queued, nothing in flight, build sequencer done
  task automatic wait_idle();
    while (pend_q.size() > 0 || start || answer_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int value);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 11'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == cfgb_pkg::CFG_WIRE_TOTAL)
      gen_wires = (value > cfgb_pkg::MaxWires) ? cfgb_pkg::MaxWires : value;
  endtask

  // mostly in-range wire, sometimes a full-width one
  function automatic int pick_wire();
    if (gen_wires == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
    return $urandom_range(0, gen_wires - 1);
  endfunction

  task automatic random_phase(int words);
    int pick;
    for (int i = 0; i < words; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)
        push_word(cfgb_pkg::MODE_LOAD, pick_wire(), pick_wire(), pick_wire(),
                  $urandom_range(0, 3) == 0, $urandom, $urandom);
      else if (pick < 60)
        push_word(cfgb_pkg::MODE_BUILD, $urandom, $urandom, $urandom, $urandom_range(0, 1),
                  $urandom, $urandom, $urandom_range(0, 1));
      else if (pick < 80)
        push_word(cfgb_pkg::MODE_QUERY, $urandom, $urandom, $urandom, $urandom_range(0, 1),
                  pick_wire(), $urandom);
      else
        push_word(cfgb_pkg::MODE_READ, $urandom, $urandom, $urandom, $urandom_range(0, 1),
                  $urandom,
                  ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                              : $urandom_range(0, 2 * gate_count + 3));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // small circuit of 16 wires
    write_reg(cfgb_pkg::CFG_WIRE_TOTAL, 16);
    write_reg(cfgb_pkg::CFG_INPUT_TOTAL, 4);
    // queries before any build are rejected
    push_word(cfgb_pkg::MODE_QUERY, 0, 0, 0, 0, 0, 0);
    push_word(cfgb_pkg::MODE_READ, 0, 0, 0, 0, 0, 0);
    // empty build, then a read past zero edges
    push_word(cfgb_pkg::MODE_BUILD, 0, 0, 0, 0, 0, 0);
    push_word(cfgb_pkg::MODE_QUERY, 0, 0, 0, 0, 0, 0);
    push_word(cfgb_pkg::MODE_READ, 0, 0, 0, 0, 0, 0);
    push_word(cfgb_pkg::MODE_QUERY, 0, 0, 0, 0, 15, 0);
    // loads: extremes, out of range on each wire, a dead gate, shared inputs
    push_word(cfgb_pkg::MODE_LOAD, 0, 15, 15, 0, 0, 0);
    push_word(cfgb_pkg::MODE_LOAD, 16, 0, 0, 0, 0, 0);
    push_word(cfgb_pkg::MODE_LOAD, 0, 1023, 0, 0, 0, 0);
    push_word(cfgb_pkg::MODE_LOAD, 0, 0, 1023, 0, 0, 0);
    push_word(cfgb_pkg::MODE_LOAD, 3, 3, 7, 1, 0, 0);
    push_word(cfgb_pkg::MODE_LOAD, 15, 0, 9, 0, 0, 0);
    push_word(cfgb_pkg::MODE_LOAD, 5, 5, 2, 0, 0, 0);
    push_word(cfgb_pkg::MODE_BUILD, 0, 0, 0, 0, 0, 0, 1'b1);
    push_word(cfgb_pkg::MODE_QUERY, 0, 0, 0, 0, 0, 0);
    push_word(cfgb_pkg::MODE_QUERY, 0, 0, 0, 0, 15, 0);
    push_word(cfgb_pkg::MODE_QUERY, 0, 0, 0, 0, 16, 0);
    push_word(cfgb_pkg::MODE_QUERY, 0, 0, 0, 0, 1023, 0);
    push_word(cfgb_pkg::MODE_READ, 0, 0, 0, 0, 0, 0);
    push_word(cfgb_pkg::MODE_READ, 0, 0, 0, 0, 0, 5);
    push_word(cfgb_pkg::MODE_READ, 0, 0, 0, 0, 0, 6);
    push_word(cfgb_pkg::MODE_READ, 0, 0, 0, 0, 0, 2047);
    // load after build leaves the old graph visible
    push_word(cfgb_pkg::MODE_LOAD, 1, 2, 3, 0, 0, 0);
    push_word(cfgb_pkg::MODE_QUERY, 0, 0, 0, 0, 1, 0);

    // zero wires: every load fails, build gives an empty graph
    write_reg(cfgb_pkg::CFG_WIRE_TOTAL, 0);
    write_reg(cfgb_pkg::CFG_INPUT_TOTAL, 0);
    random_phase(30);
    push_word(cfgb_pkg::MODE_BUILD, 0, 0, 0, 0, 0, 0);
    push_word(cfgb_pkg::MODE_QUERY, 0, 0, 0, 0, 0, 0);

    write_reg(cfgb_pkg::CFG_WIRE_TOTAL, 8);
    random_phase(80);
    write_reg(cfgb_pkg::CFG_WIRE_TOTAL, 1024);
    write_reg(cfgb_pkg::CFG_INPUT_TOTAL, 1024);
    random_phase(100);
    // above the limit acts as the limit
    write_reg(cfgb_pkg::CFG_WIRE_TOTAL, 2047);
    write_reg(cfgb_pkg::CFG_INPUT_TOTAL, 2047);
    random_phase(80);
    write_reg(cfgb_pkg::CFG_WIRE_TOTAL, $urandom_range(2, 200));
    write_reg(cfgb_pkg::CFG_INPUT_TOTAL, $urandom_range(0, 2047));
    random_phase(80);

    // shrink the wire count after loading: wide gates drop out of the build
    write_reg(cfgb_pkg::CFG_WIRE_TOTAL, 1024);
    random_phase(40);
    write_reg(cfgb_pkg::CFG_WIRE_TOTAL, 8);
    push_word(cfgb_pkg::MODE_BUILD, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 10; i++) push_word(cfgb_pkg::MODE_QUERY, 0, 0, 0, 0, i, 0);
    for (int i = 0; i < 6; i++)
      push_word(cfgb_pkg::MODE_READ, 0, 0, 0, 0, 0, $urandom_range(0, 2 * gate_count + 3));

    // rebuild over the full wire range
    write_reg(cfgb_pkg::CFG_WIRE_TOTAL, 1024);
    wait_idle();
    push_word(cfgb_pkg::MODE_BUILD, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 12; i++)
      push_word(cfgb_pkg::MODE_QUERY, 0, 0, 0, 0, $urandom_range(0, 1023), 0);
    push_word(cfgb_pkg::MODE_READ, 0, 0, 0, 0, 0, 2047);
    for (int i = 0; i < 12; i++)
      push_word(cfgb_pkg::MODE_READ, 0, 0, 0, 0, 0, $urandom_range(0, 2 * gate_count + 3));

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("tb_csr_fanout_graph_builder: done, clean");
    end else begin
      $display("tb_csr_fanout_graph_builder: done, errors");
    end
    $finish;
  end

  initial begin
    wire_total_q = 0;
    input_total_q = 0;
    gate_count = 0;
    graph_built = 1'b0;
    graph_wires = 0;
    graph_edges = 0;
    gen_wires = 0;
    took = 1'b0;
    for (int w = 0; w < cfgb_pkg::MaxWires; w++) fanout_cnt[w] = 0;
  end

endmodule
